[rtl/core/tvdm_pkg.sv]
// Shared types and constants for the tamper / vibration / door monitor.
// No dependencies; used by every module in rtl/core.
package tvdm_pkg;

  localparam int TIME_BITS_DEF  = 32;
  localparam int COUNT_BITS_DEF = 8;

  // Configuration register map
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_WINDOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIB_HOLDOFF     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTR_HOLDOFF    = 2'd3;

  // Register reset values
  localparam logic [7:0]  THRESHOLD_RST = 8'd12;
  localparam logic [15:0] WINDOW_RST    = 16'd2000;
  localparam logic [31:0] HOLDOFF_RST   = 32'd10000;

  // Stream payload widths (padded to whole bytes)
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    MODE_LOCKED = 2'd0,
    MODE_OPEN   = 2'd1,
    MODE_ALARM  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    EVT_NONE   = 2'd0,
    EVT_UNLOCK = 2'd1,
    EVT_UNAUTH = 2'd2,
    EVT_LOCK   = 2'd3
  } door_event_t;

  typedef struct packed {
    logic        clear_auth;
    logic        open;
    logic        alarm;
    mode_t       mode;
    door_event_t evt;
  } door_result_t;

endpackage

[rtl/core/tvdm_vib.sv]
// Vibration burst detector: falling-edge counter, window and alert holdoff.
// Depends on tvdm_pkg.
module tvdm_vib #(
  parameter int TIME_BITS  = tvdm_pkg::TIME_BITS_DEF,
  parameter int COUNT_BITS = tvdm_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  vib_level,
  input  logic [TIME_BITS-1:0]  now,
  input  logic [7:0]            threshold,
  input  logic [15:0]           window,
  input  logic [31:0]           holdoff,
  output logic                  alert,
  output logic [COUNT_BITS-1:0] count_next
);

  localparam int CW = (COUNT_BITS > 8)  ? COUNT_BITS : 8;
  localparam int TW = (TIME_BITS > 32)  ? TIME_BITS  : 32;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic                  prev_vib;
  logic [COUNT_BITS-1:0] edges;
  logic [TIME_BITS-1:0]  burst_start;
  logic [TIME_BITS-1:0]  last_alert;

  logic                  edge_seen;
  logic [COUNT_BITS-1:0] edges_inc;
  logic [TIME_BITS-1:0]  burst_start_next;
  logic [TIME_BITS-1:0]  last_alert_next;
  logic [TIME_BITS-1:0]  burst_el;
  logic [TIME_BITS-1:0]  alert_el;
  logic                  hit;

  always_comb begin
    edge_seen = prev_vib & ~vib_level;
    edges_inc = (edge_seen && (edges != COUNT_MAX)) ? edges + COUNT_BITS'(1) : edges;
    burst_start_next = (edge_seen && (edges == '0)) ? now : burst_start;
    burst_el = now - burst_start_next;
    alert_el = now - last_alert;
    hit = (CW'(edges_inc) >= CW'(threshold)) && (TW'(burst_el) < TW'(window));
    alert = hit && (TW'(alert_el) > TW'(holdoff));
    last_alert_next = alert ? now : last_alert;
    // drop the count on a burst hit or once the window has run out
    if (hit || (TW'(burst_el) > TW'(window))) begin
      count_next = '0;
    end else begin
      count_next = edges_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_vib    <= 1'b1;
      edges       <= '0;
      burst_start <= '0;
      last_alert  <= '0;
    end else if (en) begin
      prev_vib    <= vib_level;
      edges       <= count_next;
      burst_start <= burst_start_next;
      last_alert  <= last_alert_next;
    end
  end

endmodule

[rtl/core/tvdm_door.sv]
// Door transition logic: confirmed open/close, intrusion holdoff, safe mode.
// Depends on tvdm_pkg.
module tvdm_door #(
  parameter int TIME_BITS = tvdm_pkg::TIME_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   door_level,
  input  logic                   recheck_level,
  input  logic                   auth,
  input  logic [TIME_BITS-1:0]   now,
  input  logic [31:0]            holdoff,
  input  logic                   vib_alert,
  output tvdm_pkg::door_result_t res
);

  localparam int TW = (TIME_BITS > 32) ? TIME_BITS : 32;

  logic                 prev_door;
  logic [TIME_BITS-1:0] last_intr;
  logic                 intr_reported;
  logic                 lock_reported;
  tvdm_pkg::mode_t      mode;
  logic                 alarm;
  logic                 open;

  logic                 prev_door_next;
  logic [TIME_BITS-1:0] last_intr_next;
  logic                 intr_reported_next;
  logic                 lock_reported_next;
  logic [TIME_BITS-1:0] intr_el;
  logic                 changed;

  always_comb begin
    intr_el            = now - last_intr;
    changed            = (door_level != prev_door) && (recheck_level != prev_door);
    prev_door_next     = prev_door;
    last_intr_next     = last_intr;
    intr_reported_next = intr_reported;
    lock_reported_next = lock_reported;
    res.evt            = tvdm_pkg::EVT_NONE;
    res.clear_auth     = 1'b0;
    res.open           = open;
    res.alarm          = alarm | vib_alert;
    res.mode           = vib_alert ? tvdm_pkg::MODE_ALARM : mode;
    // door decision is taken after the vibration alert, so it wins on mode
    if (changed) begin
      prev_door_next = recheck_level;
      if (recheck_level) begin
        res.open           = 1'b1;
        lock_reported_next = 1'b0;
        if (auth) begin
          res.mode = tvdm_pkg::MODE_OPEN;
          res.evt  = tvdm_pkg::EVT_UNLOCK;
        end else if (!intr_reported && (TW'(intr_el) > TW'(holdoff))) begin
          intr_reported_next = 1'b1;
          last_intr_next     = now;
          res.mode           = tvdm_pkg::MODE_ALARM;
          res.evt            = tvdm_pkg::EVT_UNAUTH;
          res.alarm          = 1'b1;
        end
      end else begin
        res.open           = 1'b0;
        res.alarm          = 1'b0;
        res.clear_auth     = 1'b1;
        intr_reported_next = 1'b0;
        if (!lock_reported) begin
          lock_reported_next = 1'b1;
          res.mode           = tvdm_pkg::MODE_LOCKED;
          res.evt            = tvdm_pkg::EVT_LOCK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_door     <= 1'b0;
      last_intr     <= '0;
      intr_reported <= 1'b0;
      lock_reported <= 1'b0;
      mode          <= tvdm_pkg::MODE_LOCKED;
      alarm         <= 1'b0;
      open          <= 1'b0;
    end else if (en) begin
      prev_door     <= prev_door_next;
      last_intr     <= last_intr_next;
      intr_reported <= intr_reported_next;
      lock_reported <= lock_reported_next;
      mode          <= res.mode;
      alarm         <= res.alarm;
      open          <= res.open;
    end
  end

endmodule

[rtl/core/tamper_vibration_door_monitor.sv]
// Tamper / vibration / door monitor, top level.
// Pipeline: input register, then result register; the step logic between them sets the clock.
// Throughput: one poll per cycle while the sink keeps m_tready high.
// Reset (rst, synchronous): both register stages empty, configuration back to defaults,
// monitor state back to idle (door closed, mode locked, no alarm, count zero).
// Depends on tvdm_pkg, tvdm_vib, tvdm_door.
module tamper_vibration_door_monitor #(
  parameter int TIME_BITS  = tvdm_pkg::TIME_BITS_DEF,
  parameter int COUNT_BITS = tvdm_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [tvdm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tvdm_pkg::CFG_DATA_W-1:0] cfg_data,
  // poll input
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [0] vibration_level, [1] door_level, [2] door_recheck_level,
  // [3] auth_granted, [35:4] now_ms, [39:36] zero
  input  logic [tvdm_pkg::IN_DATA_W-1:0]  s_tdata,
  // result output
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [0] vibration_alert, [2:1] door_event, [4:3] safe_mode, [5] alarm_active,
  // [6] door_is_open, [7] clear_authorization, [15:8] edge_count
  output logic [tvdm_pkg::OUT_DATA_W-1:0] m_tdata
);

  localparam int EW = (COUNT_BITS > 8) ? COUNT_BITS : 8;

  // configuration registers
  logic [7:0]  burst_threshold;
  logic [15:0] burst_window;
  logic [31:0] vib_holdoff;
  logic [31:0] intr_holdoff;

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_threshold <= tvdm_pkg::THRESHOLD_RST;
      burst_window    <= tvdm_pkg::WINDOW_RST;
      vib_holdoff     <= tvdm_pkg::HOLDOFF_RST;
      intr_holdoff    <= tvdm_pkg::HOLDOFF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tvdm_pkg::REG_BURST_THRESHOLD: burst_threshold <= cfg_data[7:0];
        tvdm_pkg::REG_BURST_WINDOW:    burst_window    <= cfg_data[15:0];
        tvdm_pkg::REG_VIB_HOLDOFF:     vib_holdoff     <= cfg_data;
        tvdm_pkg::REG_INTR_HOLDOFF:    intr_holdoff    <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic                 in_valid;
  logic                 in_vib;
  logic                 in_door;
  logic                 in_recheck;
  logic                 in_auth;
  logic [31:0]          in_now;
  logic [TIME_BITS-1:0] now_t;
  logic                 advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign now_t    = TIME_BITS'(in_now);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_vib     <= s_tdata[0];
      in_door    <= s_tdata[1];
      in_recheck <= s_tdata[2];
      in_auth    <= s_tdata[3];
      in_now     <= s_tdata[35:4];
    end
  end

  // step logic
  logic                   vib_alert;
  logic [COUNT_BITS-1:0]  count_next;
  tvdm_pkg::door_result_t door_res;
  logic [EW-1:0]          count_ext;

  tvdm_vib #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_vib (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .vib_level  (in_vib),
    .now        (now_t),
    .threshold  (burst_threshold),
    .window     (burst_window),
    .holdoff    (vib_holdoff),
    .alert      (vib_alert),
    .count_next (count_next)
  );

  tvdm_door #(
    .TIME_BITS (TIME_BITS)
  ) u_door (
    .clk           (clk),
    .rst           (rst),
    .en            (advance),
    .door_level    (in_door),
    .recheck_level (in_recheck),
    .auth          (in_auth),
    .now           (now_t),
    .holdoff       (intr_holdoff),
    .vib_alert     (vib_alert),
    .res           (door_res)
  );

  assign count_ext = EW'(count_next);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {count_ext[7:0], door_res.clear_auth, door_res.open, door_res.alarm,
                  door_res.mode, door_res.evt, vib_alert};
    end
  end

endmodule

[rtl/core/tvdm_checker.sv]
// Port-level checker for the tamper / vibration / door monitor, bound to the top level.
// Depends on tvdm_pkg and tamper_vibration_door_monitor.
module tvdm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [tvdm_pkg::OUT_DATA_W-1:0] m_tdata
);

  // a result held back by the sink must not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");

  // an alert clears the edge count and raises the alarm flag, unless the door closes too
  a_alert: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> (m_tdata[15:8] == 8'd0 && (m_tdata[5] || m_tdata[7])))
    else $error("vibration alert without count clear or alarm");

  // unlock leaves the door open in open mode
  a_unlock: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2:1] == tvdm_pkg::EVT_UNLOCK) |->
      (m_tdata[6] && m_tdata[4:3] == tvdm_pkg::MODE_OPEN && !m_tdata[7]))
    else $error("unlock event with inconsistent door state");

  // an intrusion leaves the door open with the alarm raised
  a_unauth: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2:1] == tvdm_pkg::EVT_UNAUTH) |->
      (m_tdata[6] && m_tdata[5] && m_tdata[4:3] == tvdm_pkg::MODE_ALARM))
    else $error("unauthorized event with inconsistent door state");

  // lock comes with a closed door, no alarm and an authorization drop
  a_lock: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2:1] == tvdm_pkg::EVT_LOCK) |->
      (!m_tdata[6] && !m_tdata[5] && m_tdata[7] && m_tdata[4:3] == tvdm_pkg::MODE_LOCKED))
    else $error("lock event with inconsistent door state");

endmodule

bind tamper_vibration_door_monitor tvdm_checker u_tvdm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
